@@ rtl/lic_pkg.sv @@
// Shared types and constants for the LRU identifier cache directory.
// No dependencies; every other file imports this package.
package lic_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int KEY_W   = 31;
  localparam int SLOT_W  = 4;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W-1:0] rank_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [IDX_W:0]   cnt_t;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Tracker state of the slot scan, handed to the update step.
  typedef struct packed {
    logic  found;
    idx_t  hit_idx;
    logic  empty_found;
    idx_t  empty_idx;
    idx_t  victim_idx;
    rank_t victim_rank;
    key_t  victim_key;
  } scan_res_t;

endpackage

@@ rtl/lic_req_if.sv @@
// Request channel of the directory: valid/ready handshake with op and key_id.
// Depends on lic_pkg.
interface lic_req_if;
  import lic_pkg::*;

  logic valid;
  logic ready;
  logic op;
  key_t key_id;

  modport source (output valid, output op, output key_id, input ready);
  modport sink   (input valid, input op, input key_id, output ready);
endinterface

@@ rtl/lic_rsp_if.sv @@
// Response channel of the directory: valid/ready handshake with the lookup result.
// Depends on lic_pkg.
interface lic_rsp_if;
  import lic_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              evicted;
  key_t              evicted_id;

  modport source (output valid, output hit, output slot, output evicted,
                  output evicted_id, input ready);
  modport sink   (input valid, input hit, input slot, input evicted,
                  input evicted_id, output ready);
endinterface

@@ rtl/lic_scan.sv @@
// Slot scan unit: one compare per cycle while en is high; tracks hit, first empty slot and LRU victim.
// Depends on lic_pkg.
module lic_scan (
  input  logic             clk,
  input  logic             start,
  input  logic             en,
  input  lic_pkg::idx_t    idx,
  input  logic             entry_valid,
  input  lic_pkg::key_t    entry_key,
  input  lic_pkg::rank_t   entry_rank,
  input  lic_pkg::key_t    key,
  output lic_pkg::scan_res_t res
);
  import lic_pkg::*;

  always_ff @(posedge clk) begin
    if (start) begin
      res.found       <= 1'b0;
      res.hit_idx     <= '0;
      res.empty_found <= 1'b0;
      res.empty_idx   <= '0;
      res.victim_idx  <= '0;
      res.victim_rank <= '0;
      res.victim_key  <= '0;
    end else if (en) begin
      if (entry_valid && entry_key == key && !res.found) begin
        res.found   <= 1'b1;
        res.hit_idx <= idx;
      end
      if (!entry_valid && !res.empty_found) begin
        res.empty_found <= 1'b1;
        res.empty_idx   <= idx;
      end
      // slot 0 always seeds the victim so its key is captured
      if (idx == '0 || entry_rank > res.victim_rank) begin
        res.victim_idx  <= idx;
        res.victim_rank <= entry_rank;
        res.victim_key  <= entry_key;
      end
    end
  end

endmodule

@@ rtl/lru_id_cache_directory.sv @@
// Fully associative LRU identifier directory, ENTRIES slots.
// Access: the slot scan in ST_SCAN makes one compare per cycle over the key memory's single
// read port, and the result is registered in ST_UPDATE. Clear: result valid the cycle after
// accept. One beat in flight; ready returns the cycle after the result beat.
// Sync reset empties every slot, no clearing pass. Uses lic_pkg, lic_req_if, lic_rsp_if, lic_scan.
module lru_id_cache_directory (
  input  logic clk,
  input  logic rst,
  lic_req_if.sink   req,
  lic_rsp_if.source rsp
);
  import lic_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE, ST_OUT} state_t;

  state_t    state;
  key_t      key;
  cnt_t      rd_cnt;
  logic      cmp_vld;
  idx_t      cmp_idx;
  key_t      key_rd;
  logic      scan_start;
  scan_res_t res;

  logic  [ENTRIES-1:0] slot_valid;
  rank_t               recency_rank [ENTRIES];
  key_t                slot_key     [ENTRIES];

  idx_t  target;
  rank_t hit_rank;
  logic  accept;

  assign req.ready  = (state == ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign scan_start = accept;

  assign target   = res.found ? res.hit_idx :
                    (res.empty_found ? res.empty_idx : res.victim_idx);
  assign hit_rank = recency_rank[res.hit_idx];

  // key memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE && !res.found) begin
      slot_key[target] <= key;
    end
    key_rd <= slot_key[rd_cnt[IDX_W-1:0]];
  end

  lic_scan u_scan (
    .clk         (clk),
    .start       (scan_start),
    .en          (cmp_vld),
    .idx         (cmp_idx),
    .entry_valid (slot_valid[cmp_idx]),
    .entry_key   (key_rd),
    .entry_rank  (recency_rank[cmp_idx]),
    .key         (key),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rsp.valid  <= 1'b0;
      slot_valid <= '0;
      cmp_vld    <= 1'b0;
      rd_cnt     <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        recency_rank[j] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          rd_cnt  <= '0;
          cmp_vld <= 1'b0;
          if (accept) begin
            key <= req.key_id;
            if (req.op == OP_CLEAR) begin
              slot_valid     <= '0;
              for (int j = 0; j < ENTRIES; j++) begin
                recency_rank[j] <= '0;
              end
              rsp.valid      <= 1'b1;
              rsp.hit        <= 1'b0;
              rsp.slot       <= '0;
              rsp.evicted    <= 1'b0;
              rsp.evicted_id <= '0;
              state          <= ST_OUT;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_cnt < cnt_t'(ENTRIES)) begin
            rd_cnt  <= rd_cnt + 1'b1;
            cmp_vld <= 1'b1;
            cmp_idx <= rd_cnt[IDX_W-1:0];
          end else begin
            cmp_vld <= 1'b0;
          end
          if (cmp_vld && cmp_idx == idx_t'(ENTRIES - 1)) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          // on a hit only slots younger than the hit slot age
          for (int j = 0; j < ENTRIES; j++) begin
            if (idx_t'(j) == target) begin
              recency_rank[j] <= '0;
            end else if (slot_valid[j] && (!res.found || recency_rank[j] < hit_rank)) begin
              recency_rank[j] <= recency_rank[j] + 1'b1;
            end
          end
          slot_valid[target]   <= 1'b1;
          rsp.valid      <= 1'b1;
          rsp.hit        <= res.found;
          rsp.slot       <= SLOT_W'(target);
          rsp.evicted    <= !res.found && !res.empty_found;
          rsp.evicted_id <= (!res.found && !res.empty_found) ? res.victim_key : '0;
          state          <= ST_OUT;
        end
        ST_OUT: begin
          if (rsp.ready) begin
            rsp.valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a clear beat empties every slot
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == OP_CLEAR) |=> slot_valid == '0)
    else $error("slots not emptied after clear");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.hit) |-> !rsp.evicted)
    else $error("hit reported an eviction");

  // the evicted identifier is zero unless an eviction happened
  a_evict_id_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.evicted) |-> rsp.evicted_id == '0)
    else $error("evicted_id set without eviction");

  // the update leaves the target slot valid
  a_target_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |=> slot_valid[$past(target)])
    else $error("target slot not valid after update");

endmodule
